// ----- rtl/rc4_pkg.sv -----
// Shared types and constants for the RC4 stream cipher unit.
package rc4_pkg;

    localparam int BYTE_W            = 8;
    localparam int PERM_DEPTH        = 256;
    localparam int PERM_AW           = 8;
    localparam int KEY_REGS          = 4;
    localparam int KEY_BYTES         = 32;
    localparam int KEY_POS_W         = 9;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_IDX_W         = 3;
    localparam int KEY_LEN_W         = 6;
    localparam int DEF_MAX_KEY_BYTES = 32;

    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = KEY_LEN_W'(16);
    localparam logic [PERM_AW-1:0]   PERM_LAST     = PERM_AW'(PERM_DEPTH - 1);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_LENGTH = 3'd0,
        REG_KEY_0_7    = 3'd1,
        REG_KEY_8_15   = 3'd2,
        REG_KEY_16_23  = 3'd3,
        REG_KEY_24_31  = 3'd4
    } cfg_reg_t;

    // One cycle of access to the permutation memory
    typedef struct packed {
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [BYTE_W-1:0]  wr_data;
        logic [PERM_AW-1:0] rd_addr;
    } mem_req_t;

endpackage

// ----- rtl/rc4_perm_mem.sv -----
// Permutation table: 256 x 8 memory, one write port, one registered read port.
module rc4_perm_mem
    import rc4_pkg::*;
(
    input  logic              clk,
    input  mem_req_t          req,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [PERM_DEPTH];

    // Write, then read old contents on a same-address collision
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// ----- rtl/rc4_cfg_regs.sv -----
// Key configuration registers, effective key length and key byte lookup.
module rc4_cfg_regs
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES,
    parameter int KLEN_W        = $clog2(MAX_KEY_BYTES + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [KLEN_W-1:0]     key_idx,
    output logic [KLEN_W-1:0]     key_len,
    output logic [BYTE_W-1:0]     key_byte
);

    logic [KEY_LEN_W-1:0]  key_len_reg;
    logic [CFG_DATA_W-1:0] key_reg [KEY_REGS];
    logic [KEY_LEN_W-1:0]  len_nz;
    logic [KEY_POS_W-1:0]  len_sat;
    logic [KEY_POS_W-1:0]  key_pos;

    // Take register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= KEY_LEN_RESET;
            for (int r = 0; r < KEY_REGS; r++)
            begin
                key_reg[r] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_KEY_LENGTH: key_len_reg <= cfg_data[KEY_LEN_W-1:0];
                REG_KEY_0_7:    key_reg[0]  <= cfg_data;
                REG_KEY_8_15:   key_reg[1]  <= cfg_data;
                REG_KEY_16_23:  key_reg[2]  <= cfg_data;
                REG_KEY_24_31:  key_reg[3]  <= cfg_data;
                default:        ;
            endcase
        end
    end

    // Clamp key length to one at the bottom and the key limit at the top
    always_comb
    begin
        len_nz  = (key_len_reg == '0) ? KEY_LEN_W'(1) : key_len_reg;
        len_sat = (KEY_POS_W'(len_nz) > KEY_POS_W'(MAX_KEY_BYTES)) ?
                  KEY_POS_W'(MAX_KEY_BYTES) : KEY_POS_W'(len_nz);
        key_len = len_sat[KLEN_W-1:0];
    end

    // Select key byte; positions past the register file read as zero
    always_comb
    begin
        key_pos = KEY_POS_W'(key_idx);
        if (key_pos < KEY_POS_W'(KEY_BYTES))
        begin
            key_byte = key_reg[key_pos[4:3]][{key_pos[2:0], 3'b000} +: BYTE_W];
        end
        else
        begin
            key_byte = '0;
        end
    end

endmodule

// ----- rtl/rc4_stream_cipher_unit.sv -----
// RC4 stream cipher: key schedule and keystream sequencer around the permutation memory.
// Per beat: accept and read m in S_IDLE, read n in S_RD_N, swap/read k in S_SWAP_N and S_SWAP_M.
// A new byte is taken only in S_IDLE, after the previous byte has left the chain of table reads.
// A restart beat, or the first beat after reset, first runs the key schedule:
// an identity fill (S_INIT), a read-j, write-j, write-i step per entry, then S_GEN_M setup.
// Reset clears the indices, the key-ready flag and the output valid; table is unwritten.
module rc4_stream_cipher_unit
    import rc4_pkg::*;
#(
    parameter int MAX_KEY_BYTES = DEF_MAX_KEY_BYTES
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     out_byte,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int KLEN_W = $clog2(MAX_KEY_BYTES + 1);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_INIT   = 10'b00_0000_0010,
        S_KS_RJ  = 10'b00_0000_0100,
        S_KS_WJ  = 10'b00_0000_1000,
        S_KS_WI  = 10'b00_0001_0000,
        S_GEN_M  = 10'b00_0010_0000,
        S_RD_N   = 10'b00_0100_0000,
        S_SWAP_N = 10'b00_1000_0000,
        S_SWAP_M = 10'b01_0000_0000,
        S_HOLD   = 10'b10_0000_0000
    } state_t;

    state_t             state_reg, state_next;
    logic [PERM_AW-1:0] cnt_reg, cnt_next;
    logic [PERM_AW-1:0] m_reg, m_next;
    logic [PERM_AW-1:0] n_reg, n_next;
    logic [KLEN_W-1:0]  kidx_reg, kidx_next;
    logic               key_ready_reg, key_ready_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  sm_reg, sm_next;
    logic [BYTE_W-1:0]  sn_reg, sn_next;
    logic [PERM_AW-1:0] idx_reg, idx_next;
    logic [BYTE_W-1:0]  data_reg, data_next;
    logic [BYTE_W-1:0]  res_reg, res_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;

    mem_req_t           mem_req;
    logic [BYTE_W-1:0]  rd_data;
    logic [KLEN_W-1:0]  key_len;
    logic [BYTE_W-1:0]  key_byte;
    logic               in_fire;
    logic               out_free;
    logic [PERM_AW-1:0] j_sum;
    logic [BYTE_W-1:0]  ks_byte;

    rc4_perm_mem u_perm_mem
    (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    rc4_cfg_regs #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .KLEN_W        (KLEN_W)
    ) u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .key_idx   (kidx_reg),
        .key_len   (key_len),
        .key_byte  (key_byte)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;

    // Schedule swap index and keystream byte with forwarding of the pending swap
    assign j_sum   = n_reg + rd_data + key_byte;
    assign ks_byte = (idx_reg == n_reg) ? sm_reg :
                     (idx_reg == m_reg) ? sn_reg : rd_data;

    // Sequence the key schedule and keystream generation
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        kidx_next      = kidx_reg;
        key_ready_next = key_ready_reg;
        sm_next        = sm_reg;
        sn_next        = sn_reg;
        idx_next       = idx_reg;
        data_next      = data_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        mem_req        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_req.rd_addr = m_reg + PERM_AW'(1);
                if (in_fire)
                begin
                    data_next = data_byte;
                    if (restart || !key_ready_reg)
                    begin
                        cnt_next   = '0;
                        state_next = S_INIT;
                    end
                    else
                    begin
                        m_next     = m_reg + PERM_AW'(1);
                        state_next = S_RD_N;
                    end
                end
            end
            S_INIT:
            begin
                // Fill identity; last cycle also fetches entry zero
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg;
                mem_req.wr_data = cnt_reg;
                mem_req.rd_addr = '0;
                cnt_next        = cnt_reg + PERM_AW'(1);
                if (cnt_reg == PERM_LAST)
                begin
                    n_next     = '0;
                    kidx_next  = '0;
                    state_next = S_KS_RJ;
                end
            end
            S_KS_RJ:
            begin
                sm_next         = rd_data;
                n_next          = j_sum;
                mem_req.rd_addr = j_sum;
                state_next      = S_KS_WJ;
            end
            S_KS_WJ:
            begin
                sn_next         = rd_data;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg;
                mem_req.wr_data = sm_reg;
                state_next      = S_KS_WI;
            end
            S_KS_WI:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cnt_reg;
                mem_req.wr_data = sn_reg;
                mem_req.rd_addr = cnt_reg + PERM_AW'(1);
                cnt_next        = cnt_reg + PERM_AW'(1);
                kidx_next       = ((kidx_reg + KLEN_W'(1)) == key_len) ?
                                  '0 : kidx_reg + KLEN_W'(1);
                if (cnt_reg == PERM_LAST)
                begin
                    m_next         = '0;
                    n_next         = '0;
                    key_ready_next = 1'b1;
                    state_next     = S_GEN_M;
                end
                else
                begin
                    state_next = S_KS_RJ;
                end
            end
            S_GEN_M:
            begin
                mem_req.rd_addr = m_reg + PERM_AW'(1);
                m_next          = m_reg + PERM_AW'(1);
                state_next      = S_RD_N;
            end
            S_RD_N:
            begin
                sm_next         = rd_data;
                n_next          = n_reg + rd_data;
                mem_req.rd_addr = n_reg + rd_data;
                state_next      = S_SWAP_N;
            end
            S_SWAP_N:
            begin
                // Write S[n] and fetch the output entry in the same cycle
                sn_next         = rd_data;
                idx_next        = sm_reg + rd_data;
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = n_reg;
                mem_req.wr_data = sm_reg;
                mem_req.rd_addr = sm_reg + rd_data;
                state_next      = S_SWAP_M;
            end
            S_SWAP_M:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = m_reg;
                mem_req.wr_data = sn_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = data_reg ^ ks_byte;
                    state_next     = S_IDLE;
                end
                else
                begin
                    res_next   = data_reg ^ ks_byte;
                    state_next = S_HOLD;
                end
            end
            S_HOLD:
            begin
                // Hold the result until the output register frees up
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            m_reg         <= '0;
            n_reg         <= '0;
            kidx_reg      <= '0;
            key_ready_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            kidx_reg      <= kidx_next;
            key_ready_reg <= key_ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sm_reg       <= sm_next;
        sn_reg       <= sn_next;
        idx_reg      <= idx_next;
        data_reg     <= data_next;
        res_reg      <= res_next;
        out_byte_reg <= out_byte_next;
    end

endmodule

// ----- test/rc4_stream_cipher_unit_checker.sv -----
// Scoreboard for the RC4 unit: tracks the key registers, predicts each output beat and checks it.
module rc4_stream_cipher_unit_checker
    import rc4_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  logic [BYTE_W-1:0]     data_byte,
    input  logic                  restart,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  logic [BYTE_W-1:0]     out_byte,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    bytes_pending,
    output int                    bytes_checked,
    output int                    schedules_run
);

    localparam int MAX_KEY = DEF_MAX_KEY_BYTES;

    // Shadow copy of the key registers and the cipher state
    logic [KEY_LEN_W-1:0]  key_len_q;
    logic [CFG_DATA_W-1:0] key_word [KEY_REGS];
    logic [BYTE_W-1:0]     perm_tbl [PERM_DEPTH];
    logic [PERM_AW-1:0]    gen_i;
    logic [PERM_AW-1:0]    gen_j;
    logic                  sched_done;

    logic [BYTE_W-1:0]     expected_bytes [$];
    logic [BYTE_W-1:0]     want;
    int                    err_cnt;
    int                    checked_cnt;
    int                    sched_cnt;

    // Rebuild the permutation from the current key and zero both indices
    function automatic void run_key_schedule();
        int                 len;
        int                 i;
        int                 k;
        logic [PERM_AW-1:0] j;
        logic [BYTE_W-1:0]  kb;
        logic [BYTE_W-1:0]  swap;
        len = int'(key_len_q);
        if (len < 1)
            len = 1;
        if (len > MAX_KEY)
            len = MAX_KEY;
        for (i = 0; i < PERM_DEPTH; i++)
            perm_tbl[i] = BYTE_W'(i);
        j = '0;
        for (i = 0; i < PERM_DEPTH; i++)
        begin
            k = i % len;
            // positions past the last register read as zero
            kb = ((k >> 3) < KEY_REGS) ? key_word[k >> 3][8 * (k % 8) +: 8] : '0;
            j = j + perm_tbl[i] + kb;
            swap = perm_tbl[i];
            perm_tbl[i] = perm_tbl[j];
            perm_tbl[j] = swap;
        end
        gen_i = '0;
        gen_j = '0;
        sched_done = 1'b1;
    endfunction

    // Advance the generator one step and return its keystream byte
    function automatic logic [BYTE_W-1:0] next_keystream();
        logic [BYTE_W-1:0]  swap;
        logic [PERM_AW-1:0] ks_addr;
        gen_i = gen_i + 1'b1;
        gen_j = gen_j + perm_tbl[gen_i];
        swap = perm_tbl[gen_i];
        perm_tbl[gen_i] = perm_tbl[gen_j];
        perm_tbl[gen_j] = swap;
        ks_addr = perm_tbl[gen_i] + perm_tbl[gen_j];
        return perm_tbl[ks_addr];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_q = KEY_LEN_RESET;
            foreach (key_word[r])
                key_word[r] = '0;
            gen_i = '0;
            gen_j = '0;
            sched_done = 1'b0;
            expected_bytes.delete();
            err_cnt = 0;
            checked_cnt = 0;
            sched_cnt = 0;
        end
        else
        begin
            // compare the output beat with the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    err_cnt++;
                    $display("%0t: out_byte expected none got %02h", $time, out_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    checked_cnt++;
                    if (out_byte !== want)
                    begin
                        err_cnt++;
                        $display("%0t: out_byte expected %02h got %02h", $time, want, out_byte);
                    end
                end
            end

            // predict the input beat, scheduling the key first when asked or never done
            if (in_valid && in_ready)
            begin
                if (restart || !sched_done)
                begin
                    run_key_schedule();
                    sched_cnt++;
                end
                expected_bytes.push_back(data_byte ^ next_keystream());
            end

            // track register writes; unused indexes drop
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_KEY_LENGTH: key_len_q = cfg_data[KEY_LEN_W-1:0];
                    REG_KEY_0_7:    key_word[0] = cfg_data;
                    REG_KEY_8_15:   key_word[1] = cfg_data;
                    REG_KEY_16_23:  key_word[2] = cfg_data;
                    REG_KEY_24_31:  key_word[3] = cfg_data;
                    default:        ;
                endcase
            end
        end
        mismatches    <= err_cnt;
        bytes_pending <= expected_bytes.size();
        bytes_checked <= checked_cnt;
        schedules_run <= sched_cnt;
    end

endmodule

// ----- test/rc4_stream_cipher_unit_test.sv -----
// Testbench top for the RC4 unit: clock, reset, key programming, byte stimulus and verdict.
module rc4_stream_cipher_unit_test
    import rc4_pkg::*;
();

    localparam int PHASES       = 8;
    localparam int PHASE_BYTES  = 140;
    localparam int HOLD_OFF     = 400;
    localparam int SETTLE       = 8;
    localparam int CFG_IDX_LAST = (1 << CFG_IDX_W) - 1;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [BYTE_W-1:0]     data_byte;
    logic                  restart;
    logic                  out_valid;
    logic                  out_ready;
    logic [BYTE_W-1:0]     out_byte;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int mismatches;
    int bytes_pending;
    int bytes_checked;
    int schedules_run;

    bit sender_gaps;
    bit sink_stalls;
    int hold_off_cycles;

    rc4_stream_cipher_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .restart   (restart),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rc4_stream_cipher_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .restart       (restart),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .bytes_pending (bytes_pending),
        .bytes_checked (bytes_checked),
        .schedules_run (schedules_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up long after the slowest legal run would have finished
    initial
    begin
        #20_000_000;
        $display("rc4_stream_cipher_unit_test: errors");
        $finish;
    end

    // Output side: random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
                hold_off_cycles = 0;
            end
            else if (sink_stalls && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Write one register; drop the enable on the following edge
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_key(input logic [CFG_DATA_W-1:0] len_word,
                            input logic [CFG_DATA_W-1:0] w0,
                            input logic [CFG_DATA_W-1:0] w1,
                            input logic [CFG_DATA_W-1:0] w2,
                            input logic [CFG_DATA_W-1:0] w3);
        cfg_write(REG_KEY_LENGTH, len_word);
        cfg_write(REG_KEY_0_7, w0);
        cfg_write(REG_KEY_8_15, w1);
        cfg_write(REG_KEY_16_23, w2);
        cfg_write(REG_KEY_24_31, w3);
    endtask

    // Offer one beat, with an optional gap first; hold it until accepted
    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic r);
        if (sender_gaps && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= d;
        restart   <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every predicted byte has come out
    task automatic drain_outputs();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (bytes_pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] random_key_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial
    begin
        string                 plain;
        int                    p;
        int                    n;
        int                    idx;
        bit                    first_restart;
        logic [CFG_DATA_W-1:0] len_word;

        rst_n           = 1'b0;
        in_valid        = 1'b0;
        data_byte       = '0;
        restart         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        sender_gaps     = 1'b1;
        sink_stalls     = 1'b1;
        hold_off_cycles = 0;
        plain           = "Plaintext";
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset key: first beat schedules on its own, last one restarts
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        drain_outputs();

        // unused indexes must not disturb the key; then the classic three-byte key
        for (idx = int'(REG_KEY_24_31) + 1; idx <= CFG_IDX_LAST; idx++)
            cfg_write(CFG_IDX_W'(idx), '1);
        load_key(64'd3, 64'h0000_0000_0079_654B, '0, '0, '0);
        for (n = 0; n < plain.len(); n++)
            send_byte(plain[n], n == 0);
        drain_outputs();

        // zero key length acts as one byte; upper data bits are ignored
        load_key({{(CFG_DATA_W - KEY_LEN_W){1'b1}}, {KEY_LEN_W{1'b0}}},
                 random_key_word(), random_key_word(), random_key_word(), random_key_word());
        send_byte(8'h80, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        drain_outputs();

        // overlong key length saturates to the full 32 bytes
        load_key(64'd63, '1, '1, '1, '1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC3, 1'b0);
        drain_outputs();

        // new key without restart keeps the old stream until the next restart
        load_key(64'd32, {$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, {$urandom, $urandom});
        send_byte(8'h3C, 1'b0);
        send_byte(8'hE1, 1'b0);
        send_byte(8'h1E, 1'b1);
        send_byte(8'h96, 1'b0);
        drain_outputs();

        // shortest key
        load_key(64'd1, {$urandom, $urandom}, '0, '0, '0);
        send_byte(8'h69, 1'b1);
        send_byte(8'hF0, 1'b0);
        drain_outputs();

        // random phases: new key each phase, long streams with rare restarts
        for (p = 0; p < PHASES; p++)
        begin
            sender_gaps = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            sink_stalls = (p < PHASES - 2) && ($urandom_range(0, 3) != 0);
            len_word = {$urandom, $urandom};
            case ($urandom_range(0, 7))
                0:       len_word[KEY_LEN_W-1:0] = '0;
                1:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(1);
                2:       len_word[KEY_LEN_W-1:0] = KEY_LEN_W'(KEY_BYTES);
                3:       len_word[KEY_LEN_W-1:0] = '1;
                default: ;
            endcase
            load_key(len_word, random_key_word(), random_key_word(),
                     random_key_word(), random_key_word());
            // back-pressure the output hard while beats keep coming
            if (p == 2)
            begin
                sender_gaps = 1'b0;
                hold_off_cycles = HOLD_OFF;
            end
            first_restart = $urandom_range(0, 1);
            for (n = 0; n < PHASE_BYTES; n++)
                send_byte(BYTE_W'($urandom_range(0, 255)),
                          (n == 0) ? first_restart : ($urandom_range(0, 39) == 0));
            drain_outputs();
        end

        $display("run covered %0d bytes over %0d key schedules, key lengths 0 to 63,",
                 bytes_checked, schedules_run);
        $display("unused register writes, rekey without restart and a %0d-cycle output hold",
                 HOLD_OFF);
        if (mismatches == 0)
            $display("rc4_stream_cipher_unit_test: clean");
        else
            $display("rc4_stream_cipher_unit_test: errors");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/rc4_pkg.sv
rtl/rc4_perm_mem.sv
rtl/rc4_cfg_regs.sv
rtl/rc4_stream_cipher_unit.sv
test/rc4_stream_cipher_unit_checker.sv
test/rc4_stream_cipher_unit_test.sv
